[rtl/cck_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and functions of the ChaCha20 keystream block unit.
// Depends on nothing; every other file in rtl imports it.
package cck_pkg;

    // Block layout
    localparam int unsigned NUM_WORDS   = 16;
    localparam int unsigned NUM_SLICES  = 8;
    localparam int unsigned NUM_DROUNDS = 10;

    // Quarter-round steps per double round: four column steps, four diagonal steps
    localparam logic [2:0] STEP_LAST = 3'd7;

    // Counter queue between the front and the round pipeline
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic [2:0] CFG_KEY_0    = 3'd0;
    localparam logic [2:0] CFG_KEY_1    = 3'd1;
    localparam logic [2:0] CFG_KEY_2    = 3'd2;
    localparam logic [2:0] CFG_KEY_3    = 3'd3;
    localparam logic [2:0] CFG_NONCE_LO = 3'd4;
    localparam logic [2:0] CFG_NONCE_HI = 3'd5;

    typedef logic [31:0] t_word;
    typedef logic [NUM_WORDS-1:0][31:0] t_state;

    // "expand 32-byte k"
    localparam t_word SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

    typedef struct packed {
        logic [3:0][63:0] key;
        logic [63:0]      nonce_lo;
        logic [31:0]      nonce_hi;
    } t_cfg;

    // One block in flight: working state and its block counter
    typedef struct packed {
        t_state state;
        t_word  ctr;
    } t_blk;

    function automatic t_word cck_rotl(t_word v, int unsigned r);
        return (v << r) | (v >> (32 - r));
    endfunction

    // Starting state: constants, key, counter, nonce
    function automatic t_state cck_init(t_cfg cfg, t_word ctr);
        t_state y;
        for (int i = 0; i < 4; i++) begin
            y[i]             = SIGMA[i];
            y[4'(4 + 2 * i)] = cfg.key[i][31:0];
            y[4'(5 + 2 * i)] = cfg.key[i][63:32];
        end
        y[12] = ctr;
        y[13] = cfg.nonce_lo[31:0];
        y[14] = cfg.nonce_lo[63:32];
        y[15] = cfg.nonce_hi;
        return y;
    endfunction

    // One quarter-round step on all four lanes: one add, one xor, one rotate.
    // Bit 2 of the step picks diagonal lanes, bits 1:0 pick the step.
    function automatic t_state cck_step(t_state x, logic [2:0] s);
        t_state     y;
        logic [1:0] la;
        logic [1:0] lb;
        logic [1:0] lc;
        logic [1:0] ld;
        t_word      sum;
        y = x;
        for (int q = 0; q < 4; q++) begin
            la = 2'(q);
            lb = s[2] ? 2'(q + 1) : 2'(q);
            lc = s[2] ? 2'(q + 2) : 2'(q);
            ld = s[2] ? 2'(q + 3) : 2'(q);
            unique case (s[1:0])
                2'd0: begin
                    sum             = x[{2'b00, la}] + x[{2'b01, lb}];
                    y[{2'b00, la}]  = sum;
                    y[{2'b11, ld}]  = cck_rotl(x[{2'b11, ld}] ^ sum, 16);
                end
                2'd1: begin
                    sum             = x[{2'b10, lc}] + x[{2'b11, ld}];
                    y[{2'b10, lc}]  = sum;
                    y[{2'b01, lb}]  = cck_rotl(x[{2'b01, lb}] ^ sum, 12);
                end
                2'd2: begin
                    sum             = x[{2'b00, la}] + x[{2'b01, lb}];
                    y[{2'b00, la}]  = sum;
                    y[{2'b11, ld}]  = cck_rotl(x[{2'b11, ld}] ^ sum, 8);
                end
                default: begin
                    sum             = x[{2'b10, lc}] + x[{2'b11, ld}];
                    y[{2'b10, lc}]  = sum;
                    y[{2'b01, lb}]  = cck_rotl(x[{2'b01, lb}] ^ sum, 7);
                end
            endcase
        end
        return y;
    endfunction

endpackage

[rtl/cck_front.sv]
`timescale 1ns / 1ps
// Front end: takes block counter requests and queues them for the round pipeline.
// Depends on cck_pkg.
module cck_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cck_pkg::t_word i_block_counter,
    output logic           o_q_valid,
    input  logic           i_q_ready,
    output cck_pkg::t_word o_q_ctr
);
    import cck_pkg::*;

    t_word               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_AW:0]   r_count;
    logic                w_push;
    logic                w_pop;

    assign o_in_ready = (r_count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_q_valid  = (r_count != '0);
    assign o_q_ctr    = r_mem[r_rptr];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = o_q_valid && i_q_ready;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (QUEUE_AW + 1)'(1);
            end else if (!w_push && w_pop) begin
                r_count <= r_count - (QUEUE_AW + 1)'(1);
            end
        end
    end

    // Store an incoming counter
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_block_counter;
        end
    end

endmodule

[rtl/cck_dround.sv]
`timescale 1ns / 1ps
// One double-round stage: eight quarter-round steps on one block.
// Depends on cck_pkg.
module cck_dround (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cck_pkg::t_blk i_in_blk,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output cck_pkg::t_blk o_out_blk
);
    import cck_pkg::*;

    logic       r_busy;
    logic [2:0] r_step;
    t_blk       r_blk;
    t_state     w_next;
    logic       w_take;
    logic       w_give;

    assign w_next      = cck_step(r_blk.state, r_step);
    // The final step is handed on combinationally, without being registered
    assign o_out_valid = r_busy && (r_step == STEP_LAST);
    assign o_out_blk   = '{state: w_next, ctr: r_blk.ctr};
    assign w_give      = o_out_valid && i_out_ready;
    assign o_in_ready  = !r_busy || w_give;
    assign w_take      = i_in_valid && o_in_ready;

    // Step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (w_take) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (w_give) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (r_busy && (r_step != STEP_LAST)) begin
            r_step <= r_step + 3'd1;
        end
    end

    // Load a new block or apply one step; hold at the last step while stalled
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_blk <= i_in_blk;
        end else if (r_busy && (r_step != STEP_LAST)) begin
            r_blk.state <= w_next;
        end
    end

`ifndef SYNTHESIS
    a_step_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_step != STEP_LAST)) |=> (r_busy && (r_step == $past(r_step) + 3'd1)))
        else $error("double-round stage skipped or lost a step");
    a_idle_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_step == '0))
        else $error("idle stage holds a nonzero step");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_blk)))
        else $error("stalled stage changed its block");
`endif

endmodule

[rtl/cck_out.sv]
`timescale 1ns / 1ps
// Back end output: adds the starting state and sends the block as eight 64-bit slices.
// Depends on cck_pkg.
module cck_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cck_pkg::t_cfg i_cfg,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cck_pkg::t_blk i_in_blk,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [2:0]    o_word_index,
    output logic [63:0]   o_keystream_word,
    output logic          o_last_word
);
    import cck_pkg::*;

    logic       r_full;
    logic [2:0] r_idx;
    t_blk       r_blk;
    t_state     w_init;
    t_word      w_lo;
    t_word      w_hi;
    logic       w_last;
    logic       w_give;
    logic       w_take;

    assign w_last      = (r_idx == 3'(NUM_SLICES - 1));
    assign w_give      = r_full && i_out_ready;
    assign o_in_ready  = !r_full || (w_last && i_out_ready);
    assign w_take      = i_in_valid && o_in_ready;

    // Feed-forward add for the two words of the current slice
    assign w_init           = cck_init(i_cfg, r_blk.ctr);
    assign w_lo             = r_blk.state[{r_idx, 1'b0}] + w_init[{r_idx, 1'b0}];
    assign w_hi             = r_blk.state[{r_idx, 1'b1}] + w_init[{r_idx, 1'b1}];
    assign o_out_valid      = r_full;
    assign o_word_index     = r_idx;
    assign o_keystream_word = {w_hi, w_lo};
    assign o_last_word      = w_last;

    // Slice counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= '0;
        end else if (w_take) begin
            r_full <= 1'b1;
            r_idx  <= '0;
        end else if (w_give) begin
            if (w_last) begin
                r_full <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // Hold the finished block until its last slice is taken
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_blk <= i_in_blk;
        end
    end

`ifndef SYNTHESIS
    a_slice_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_give && !w_last) |=> (r_full && (r_idx == $past(r_idx) + 3'd1)))
        else $error("output slice skipped");
    a_block_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_give && w_last) |=> (r_idx == '0))
        else $error("new block did not start at slice zero");
`endif

endmodule

[rtl/chacha20_keystream_block_unit.sv]
`timescale 1ns / 1ps
// Top level of the ChaCha20 keystream block unit: config registers, counter queue,
// ten double-round stages and the slice output. Depends on cck_pkg and all cck_ modules.
//
//  channel   direction  handshake               payload
//  in        input      i_in_valid/o_in_ready   i_block_counter[31:0]
//  out       output     o_out_valid/i_out_ready o_word_index, o_keystream_word, o_last_word
//  cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index[2:0], i_cfg_data[63:0]
//
// Throughput is bounded both by the eight quarter-round steps each double-round stage
// takes and by the eight slices of the output port; a stage takes a new block only as its last one leaves.
// A request passes from the queue through the ten stages to the output. Up to 2 queued,
// 10 in rounds and 1 in output are in flight at once.
// Reset is synchronous, active low; config registers reset to zero.
// Each stage and the output stall on their own; the queue absorbs input during stalls.
module chacha20_keystream_block_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_block_counter,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_word_index,
    output logic [63:0] o_keystream_word,
    output logic        o_last_word
);
    import cck_pkg::*;

    t_cfg  r_cfg;
    logic  w_q_valid;
    logic  w_q_ready;
    t_word w_q_ctr;
    logic  w_vld [NUM_DROUNDS + 1];
    logic  w_rdy [NUM_DROUNDS + 1];
    t_blk  w_blk [NUM_DROUNDS + 1];

    assign o_cfg_ready = 1'b1;

    // Configuration writes; drop indexes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEY_0:    r_cfg.key[0]   <= i_cfg_data;
                CFG_KEY_1:    r_cfg.key[1]   <= i_cfg_data;
                CFG_KEY_2:    r_cfg.key[2]   <= i_cfg_data;
                CFG_KEY_3:    r_cfg.key[3]   <= i_cfg_data;
                CFG_NONCE_LO: r_cfg.nonce_lo <= i_cfg_data;
                CFG_NONCE_HI: r_cfg.nonce_hi <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    cck_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_block_counter (i_block_counter),
        .o_q_valid       (w_q_valid),
        .i_q_ready       (w_q_ready),
        .o_q_ctr         (w_q_ctr)
    );

    // Build the starting state as the block enters the first stage
    assign w_vld[0]  = w_q_valid;
    assign w_q_ready = w_rdy[0];
    assign w_blk[0]  = '{state: cck_init(r_cfg, w_q_ctr), ctr: w_q_ctr};

    for (genvar g = 0; g < NUM_DROUNDS; g++) begin : g_dround
        cck_dround u_dround (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_in_valid  (w_vld[g]),
            .o_in_ready  (w_rdy[g]),
            .i_in_blk    (w_blk[g]),
            .o_out_valid (w_vld[g+1]),
            .i_out_ready (w_rdy[g+1]),
            .o_out_blk   (w_blk[g+1])
        );
    end

    cck_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_in_valid       (w_vld[NUM_DROUNDS]),
        .o_in_ready       (w_rdy[NUM_DROUNDS]),
        .i_in_blk         (w_blk[NUM_DROUNDS]),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_word_index     (o_word_index),
        .o_keystream_word (o_keystream_word),
        .o_last_word      (o_last_word)
    );

endmodule
